>>> hdl/oirq_pkg.sv
// package for the ordered insert ring queue
// holds default sizes, the operation codes and the cell control struct; no dependencies
package oirq_pkg;

	localparam int DEPTH_DEF        = 16;
	localparam int HANDLE_WIDTH_DEF = 16;
	localparam int KEY_WIDTH_DEF    = 16;

	// operation codes carried in the input tuser
	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2,
		KIND_READ   = 2'd3
	} kind_t;

	// per-cycle command broadcast to every cell, already qualified by the transaction
	typedef struct packed {
		logic append;
		logic insert;
		logic remove;
	} oirq_ctrl_t;

endpackage

>>> hdl/ordered_insert_ring_queue.sv
// top level of the ordered insert ring queue: a row of oirq_cell storage cells
// ordered from the head, a fill counter and a registered result; depends on oirq_pkg and oirq_cell
//
// The queue holds up to DEPTH-1 entries of a task handle and a signed key, kept in
// a row of cells in queue order with the head in the first cell. Each input
// transaction is one operation selected by s_tuser: append at the tail, priority
// insert in front of the first entry whose key is strictly greater (equal keys keep
// arrival order), remove head or read head. Every operation returns one result
// transaction with a success flag, the head entry for remove and read, and the fill
// count with empty and full flags after the operation. Every cell compares its key
// with the new one and shifts or loads in the same cycle, and the insert position
// ripples through the row as a prefix of the compare results. A new operation is
// taken in every cycle in which the output register is empty or being drained, so
// the sustained rate is one per cycle.
module ordered_insert_ring_queue import oirq_pkg::*; #(
	parameter int DEPTH        = DEPTH_DEF,
	parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF,
	parameter int KEY_WIDTH    = KEY_WIDTH_DEF,
	localparam int CNT_W       = $clog2(DEPTH),
	localparam int IN_W        = ((HANDLE_WIDTH + KEY_WIDTH + 7) / 8) * 8,
	localparam int OUT_RAW     = HANDLE_WIDTH + KEY_WIDTH + CNT_W + 2,
	localparam int OUT_W       = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // task_handle, task_key, zero pad
	input  logic [1:0]       s_tuser,   // kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,   // head_handle, head_key, count, is_empty_flag,
	                                    // is_full_flag, zero pad
	output logic [0:0]       m_tuser    // ok
);

	localparam int NCELL = DEPTH - 1;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH - 1);

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_nxt;
	logic                    m_tvalid_q;
	logic                    res_ok_q;
	logic [HANDLE_WIDTH-1:0] res_handle_q;
	logic [KEY_WIDTH-1:0]    res_key_q;
	logic [CNT_W-1:0]        res_count_q;

	logic                    accept;
	kind_t                   kind;
	logic                    is_full;
	logic                    queue_empty;
	logic                    is_ins;
	logic                    res_ok;
	logic [HANDLE_WIDTH-1:0] res_handle;
	logic [KEY_WIDTH-1:0]    res_key;
	logic [HANDLE_WIDTH-1:0] in_handle;
	logic [KEY_WIDTH-1:0]    in_key;
	oirq_ctrl_t              ctrl;

	logic [HANDLE_WIDTH-1:0] cell_handle [NCELL];
	logic [KEY_WIDTH-1:0]    cell_key    [NCELL];
	logic                    cell_gt     [NCELL];
	logic                    found       [NCELL];

	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign kind      = kind_t'(s_tuser);
	assign in_handle = s_tdata[HANDLE_WIDTH-1:0];
	assign in_key    = s_tdata[HANDLE_WIDTH+KEY_WIDTH-1:HANDLE_WIDTH];

	// decode the operation and work out the result
	always_comb begin
		is_full      = count_q == FULL_CNT;
		queue_empty  = count_q == '0;
		is_ins       = (kind == KIND_APPEND) || (kind == KIND_INSERT);
		ctrl.append  = accept && (kind == KIND_APPEND) && !is_full;
		ctrl.insert  = accept && (kind == KIND_INSERT) && !is_full;
		ctrl.remove  = accept && (kind == KIND_REMOVE) && !queue_empty;
		res_ok       = is_ins ? !is_full : !queue_empty;
		res_handle   = '0;
		res_key      = '0;
		if (!is_ins && !queue_empty) begin
			res_handle = cell_handle[0];
			res_key    = cell_key[0];
		end
		count_nxt = count_q;
		if (ctrl.append || ctrl.insert) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ctrl.remove) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// insert position: set in every cell behind the first greater key
	assign found[0] = 1'b0;
	for (genvar i = 1; i < NCELL; i++) begin : g_found
		assign found[i] = found[i-1] || cell_gt[i-1];
	end

	// the cell row, head in cell zero
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic [HANDLE_WIDTH-1:0] left_handle;
		logic [KEY_WIDTH-1:0]    left_key;
		logic [HANDLE_WIDTH-1:0] right_handle;
		logic [KEY_WIDTH-1:0]    right_key;

		if (i == 0) begin : g_first
			assign left_handle = in_handle;
			assign left_key    = in_key;
		end else begin : g_mid
			assign left_handle = cell_handle[i-1];
			assign left_key    = cell_key[i-1];
		end
		if (i == NCELL - 1) begin : g_last
			assign right_handle = in_handle;
			assign right_key    = in_key;
		end else begin : g_inner
			assign right_handle = cell_handle[i+1];
			assign right_key    = cell_key[i+1];
		end

		oirq_cell #(
			.HANDLE_WIDTH (HANDLE_WIDTH),
			.KEY_WIDTH    (KEY_WIDTH),
			.CNT_W        (CNT_W),
			.INDEX        (i)
		) u_cell (
			.clk          (clk),
			.ctrl         (ctrl),
			.count        (count_q),
			.new_handle   (in_handle),
			.new_key      (in_key),
			.left_handle  (left_handle),
			.left_key     (left_key),
			.right_handle (right_handle),
			.right_key    (right_key),
			.found_in     (found[i]),
			.gt           (cell_gt[i]),
			.handle       (cell_handle[i]),
			.key          (cell_key[i])
		);
	end

	// fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			res_ok_q     <= res_ok;
			res_handle_q <= res_handle;
			res_key_q    <= res_key;
			res_count_q  <= count_nxt;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tuser[0] = res_ok_q;
	assign m_tdata    = OUT_W'({(res_count_q == FULL_CNT), (res_count_q == '0),
	                            res_count_q, res_key_q, res_handle_q});

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("fill count above capacity");

	a_remove_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (kind == KIND_REMOVE) && queue_empty) |=> (count_q == '0))
		else $error("remove on empty queue changed the count");

	a_insert_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_ins && !is_full) |=> (m_tvalid && m_tuser[0]))
		else $error("insert with room not reported as stored");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("count moved without a transaction");
`endif

endmodule

>>> hdl/oirq_cell.sv
// one storage cell of the queue row: holds a handle and key at a fixed position
// from the head; depends on oirq_pkg
module oirq_cell import oirq_pkg::*; #(
	parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF,
	parameter int KEY_WIDTH    = KEY_WIDTH_DEF,
	parameter int CNT_W        = 4,
	parameter int INDEX        = 0
) (
	input  logic                    clk,
	input  oirq_ctrl_t              ctrl,
	input  logic [CNT_W-1:0]        count,
	input  logic [HANDLE_WIDTH-1:0] new_handle,
	input  logic [KEY_WIDTH-1:0]    new_key,
	input  logic [HANDLE_WIDTH-1:0] left_handle,
	input  logic [KEY_WIDTH-1:0]    left_key,
	input  logic [HANDLE_WIDTH-1:0] right_handle,
	input  logic [KEY_WIDTH-1:0]    right_key,
	input  logic                    found_in,
	output logic                    gt,
	output logic [HANDLE_WIDTH-1:0] handle,
	output logic [KEY_WIDTH-1:0]    key
);

	logic [HANDLE_WIDTH-1:0] handle_q;
	logic [KEY_WIDTH-1:0]    key_q;
	logic                    occupied;
	logic                    at_tail;

	// compare the incoming key against the stored one
	always_comb begin
		occupied = CNT_W'(INDEX) < count;
		at_tail  = CNT_W'(INDEX) == count;
		gt       = ctrl.insert && occupied && ($signed(new_key) < $signed(key_q));
	end

	// shift toward the head, shift toward the tail, or load the new entry
	always_ff @(posedge clk) begin
		if (ctrl.remove) begin
			handle_q <= right_handle;
			key_q    <= right_key;
		end else if (ctrl.insert && found_in) begin
			handle_q <= left_handle;
			key_q    <= left_key;
		end else if ((ctrl.insert && (gt || at_tail)) || (ctrl.append && at_tail)) begin
			handle_q <= new_handle;
			key_q    <= new_key;
		end
	end

	assign handle = handle_q;
	assign key    = key_q;

endmodule

>>> dv/oirq_checker.sv
`timescale 1ns / 100ps
// checker for the ordered insert ring queue: watches both stream channels, predicts each result
// from its own copy of the queue and compares; depends on oirq_pkg
module oirq_checker import oirq_pkg::*; #(
	localparam int DEPTH   = DEPTH_DEF,
	localparam int HW      = HANDLE_WIDTH_DEF,
	localparam int KW      = KEY_WIDTH_DEF,
	localparam int CNT_W   = $clog2(DEPTH),
	localparam int IN_W    = ((HW + KW + 7) / 8) * 8,
	localparam int OUT_RAW = HW + KW + CNT_W + 2,
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // task_handle, task_key, zero pad
	input  logic [1:0]       s_tuser,   // kind
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // head_handle, head_key, count, is_empty_flag,
	                                    // is_full_flag, zero pad
	input  logic [0:0]       m_tuser,   // ok
	output int               mismatch_count,
	output int               replies_outstanding
);

	// one result, laid out so that {m_tdata[OUT_RAW-1:0], m_tuser} maps straight onto it
	typedef struct packed {
		logic                 full;
		logic                 empty;
		logic [CNT_W-1:0]     count;
		logic signed [KW-1:0] key;
		logic [HW-1:0]        handle;
		logic                 ok;
	} reply_t;

	// shadow copy of the ring
	logic [HW-1:0]        shadow_handle [DEPTH];
	logic signed [KW-1:0] shadow_key    [DEPTH];
	int                   head_idx;
	int                   tail_idx;
	reply_t               pending_replies [$];

	function automatic int ring_step(input int i);
		return (i + 1) % DEPTH;
	endfunction

	function automatic int ring_back(input int i);
		return (i + DEPTH - 1) % DEPTH;
	endfunction

	// apply one operation to the shadow ring and work out its result
	task automatic apply_operation(input kind_t op, input logic [HW-1:0] handle,
			input logic signed [KW-1:0] key, output reply_t reply);
		int level;
		int slot;
		int i;
		level = (tail_idx + DEPTH - head_idx) % DEPTH;
		reply = '0;
		case (op)
			KIND_APPEND, KIND_INSERT: begin
				if (level != DEPTH - 1) begin
					slot = tail_idx;
					if (op == KIND_INSERT) begin
						// first stored key strictly greater wins, so equal keys stay in order
						for (i = head_idx; i != tail_idx; i = ring_step(i)) begin
							if (key < shadow_key[i]) begin
								slot = i;
								break;
							end
						end
						for (i = tail_idx; i != slot; i = ring_back(i)) begin
							shadow_handle[i] = shadow_handle[ring_back(i)];
							shadow_key[i]    = shadow_key[ring_back(i)];
						end
					end
					shadow_handle[slot] = handle;
					shadow_key[slot]    = key;
					tail_idx = ring_step(tail_idx);
					reply.ok = 1'b1;
				end
			end
			default: begin
				if (head_idx != tail_idx) begin
					reply.ok     = 1'b1;
					reply.handle = shadow_handle[head_idx];
					reply.key    = shadow_key[head_idx];
					if (op == KIND_REMOVE)
						head_idx = ring_step(head_idx);
				end
			end
		endcase
		level = (tail_idx + DEPTH - head_idx) % DEPTH;
		reply.count = level[CNT_W-1:0];
		reply.empty = (level == 0);
		reply.full  = (level == DEPTH - 1);
	endtask

	// result side is compared before the new input is predicted: the output is registered
	always @(posedge clk or negedge arst_n) begin
		reply_t seen;
		reply_t want;
		if (!arst_n) begin
			head_idx = 0;
			tail_idx = 0;
			pending_replies.delete();
			mismatch_count      <= 0;
			replies_outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen = {m_tdata[OUT_RAW-1:0], m_tuser[0]};
				if (pending_replies.size() == 0) begin
					mismatch_count <= mismatch_count + 1;
					$display("%0t: result transaction with none expected: ok=%0b handle=%h key=%0d",
						$time, seen.ok, seen.handle, seen.key);
				end else begin
					want = pending_replies.pop_front();
					if (seen !== want) begin
						mismatch_count <= mismatch_count + 1;
						$display("%0t: expected ok=%0b handle=%h key=%0d count=%0d empty=%0b full=%0b",
							$time, want.ok, want.handle, want.key, want.count, want.empty,
							want.full);
						$display("%0t:   actual ok=%0b handle=%h key=%0d count=%0d empty=%0b full=%0b",
							$time, seen.ok, seen.handle, seen.key, seen.count, seen.empty,
							seen.full);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_operation(kind_t'(s_tuser), s_tdata[HW-1:0], s_tdata[HW+KW-1:HW], want);
				pending_replies.push_back(want);
			end
			replies_outstanding <= pending_replies.size();
		end
	end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// top of the ordered insert ring queue testbench: clock, reset, stimulus, backpressure and verdict
// depends on oirq_pkg, ordered_insert_ring_queue and oirq_checker
module testbench;
	import oirq_pkg::*;

	localparam int HW             = HANDLE_WIDTH_DEF;
	localparam int KW             = KEY_WIDTH_DEF;
	localparam int CNT_W          = $clog2(DEPTH_DEF);
	localparam int IN_W           = ((HW + KW + 7) / 8) * 8;
	localparam int OUT_W          = ((HW + KW + CNT_W + 2 + 7) / 8) * 8;
	localparam int RANDOM_OPS     = 1925;
	localparam int WATCHDOG_LIMIT = 3000;

	// operation mixes for the random phases
	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [1:0]       s_tuser;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0]       m_tuser;
	int               mismatch_count;
	int               replies_outstanding;
	int               idle_cycles;
	bit               sender_eager;

	ordered_insert_ring_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	oirq_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_tvalid            (s_tvalid),
		.s_tready            (s_tready),
		.s_tdata             (s_tdata),
		.s_tuser             (s_tuser),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.m_tuser             (m_tuser),
		.mismatch_count      (mismatch_count),
		.replies_outstanding (replies_outstanding)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// keys: a narrow band to get ties, the extremes, or anything
	function automatic logic signed [KW-1:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return KW'($signed($urandom_range(0, 6)) - 3);
		if (r < 50) begin
			case ($urandom_range(0, 5))
				0:       return {1'b1, {(KW-1){1'b0}}};
				1:       return {1'b1, {(KW-2){1'b0}}, 1'b1};
				2:       return {1'b0, {(KW-1){1'b1}}};
				3:       return {1'b0, {(KW-2){1'b1}}, 1'b0};
				4:       return '1;
				default: return '0;
			endcase
		end
		return KW'($urandom);
	endfunction

	function automatic kind_t pick_kind(input mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL:
				return (r < 40) ? KIND_APPEND : (r < 75) ? KIND_INSERT :
					(r < 90) ? KIND_REMOVE : KIND_READ;
			MIX_DRAIN:
				return (r < 15) ? KIND_APPEND : (r < 30) ? KIND_INSERT :
					(r < 85) ? KIND_REMOVE : KIND_READ;
			default:
				return kind_t'($urandom_range(0, 3));
		endcase
	endfunction

	// one input transaction, returns at the edge where it is accepted
	task automatic send_op(input kind_t op, input logic [HW-1:0] handle,
			input logic signed [KW-1:0] key);
		int gap;
		gap = sender_eager ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= IN_W'({key, handle});
		do @(posedge clk); while (!s_tready);
	endtask

	// hold the sender off until every result is back
	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (replies_outstanding != 0);
	endtask

	// stimulus and verdict
	initial begin : stimulus
		int   i;
		int   sent;
		int   phase;
		int   phase_len;
		mix_t mix;
		arst_n       <= 1'b0;
		s_tvalid     <= 1'b0;
		s_tdata      <= '0;
		s_tuser      <= KIND_APPEND;
		sender_eager = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, extremes of handle and key, ties at zero and at the top key
		send_op(KIND_READ,   16'h0000, 16'sh0000);
		send_op(KIND_REMOVE, 16'hffff, 16'sh7fff);
		send_op(KIND_INSERT, 16'hffff, 16'sh0000);
		send_op(KIND_INSERT, 16'h0001, 16'sh8000);
		send_op(KIND_APPEND, 16'h0002, 16'sh7fff);
		send_op(KIND_INSERT, 16'h0003, 16'sh0000);
		send_op(KIND_INSERT, 16'h0004, 16'sh7fff);
		send_op(KIND_INSERT, 16'h0005, 16'shffff);
		send_op(KIND_READ,   16'h0000, 16'sh0000);
		send_op(KIND_REMOVE, 16'h0000, 16'sh0000);
		send_op(KIND_INSERT, 16'h0000, 16'sh8000);
		// fill up, then inserts into a full queue are refused
		for (i = 0; i < 9; i++)
			send_op((i % 2) ? KIND_INSERT : KIND_APPEND, 16'ha5a0 + i[15:0],
				16'(i * 7919 - 20000));
		send_op(KIND_APPEND, 16'h1234, 16'sh0001);
		send_op(KIND_INSERT, 16'h5678, 16'sh8000);
		send_op(KIND_READ,   16'h0000, 16'sh0000);
		send_op(KIND_REMOVE, 16'h0000, 16'sh0000);

		// random phases, each with its own mix and sender temper
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_OPS) begin
			mix          = mix_t'($urandom_range(0, 2));
			phase_len    = $urandom_range(20, 80);
			sender_eager = ($urandom_range(0, 3) == 0);
			if (phase == 0 || $urandom_range(0, 4) == 0)
				wait_for_replies();
			for (i = 0; i < phase_len && sent < RANDOM_OPS; i++) begin
				send_op(pick_kind(mix), HW'($urandom), pick_key());
				sent++;
			end
			phase++;
		end

		wait_for_replies();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// result side backpressure, with stall-free stretches
	initial begin : sink_stalls
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) < 3) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

endmodule

>>> sim.f
hdl/oirq_pkg.sv
hdl/oirq_cell.sv
hdl/ordered_insert_ring_queue.sv
dv/oirq_checker.sv
dv/testbench.sv
